// ----- rtl/core/accel_coherence_mode_selector_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the coherence mode selector
// Immediate-implication and next-cycle checks, compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ACCEL_COHERENCE_MODE_SELECTOR_UNIT_MACROS_SVH
`define ACCEL_COHERENCE_MODE_SELECTOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define ACMS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acms: check failed");
`define ACMS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acms: check failed");
`else
`define ACMS_ASSERT_IMP(label, ante, cons)
`define ACMS_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/acms_pkg.sv -----
// ----------------------------------------------------------------------------
// acms_pkg
// Shared widths, codes, types and saturating arithmetic.
// ----------------------------------------------------------------------------
package acms_pkg;

    localparam int ACC_INDEX_W  = 4;
    localparam int IN_BYTES_W   = 24;
    localparam int RATIO_W      = 8;
    localparam int POLICY_W     = 2;
    localparam int MEM_INDEX_W  = 2;
    localparam int MODE_W       = 2;
    localparam int FP_W         = 27;
    localparam int SUM_W        = 32;
    localparam int COUNT_W      = 5;
    localparam int SHIFT_W      = 5;

    // entry index widened to cover up to 128 entries, memory index up to 16
    localparam int ENTRY_WIDE_W = 7;
    localparam int MEM_WIDE_W   = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int QUEUE_DEPTH  = 2;
    localparam int DIV_STEPS    = IN_BYTES_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);

    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 2;

    localparam logic [REG_IDX_W-1:0] REG_ACCESS_SHIFT  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRIVATE_CACHE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LLC           = 2'd2;

    localparam logic [SUM_W-1:0] PRIVATE_RESET = 32'd65536;
    localparam logic [SUM_W-1:0] LLC_RESET     = 32'd1048576;

    localparam logic [POLICY_W-1:0] POL_PREFERRED    = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LEAST_LOADED = 2'd1;

    localparam logic FUNC_DONE = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        COH_FULL   = 2'd0,
        COH_LLC    = 2'd1,
        COH_NONCOH = 2'd2
    } coh_mode_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] access_shift;
        logic [SUM_W-1:0]   private_cache_bytes;
        logic [SUM_W-1:0]   llc_bytes;
    } cfg_t;

    typedef struct packed {
        logic                   is_done;
        logic                   in_range;
        logic [ACC_INDEX_W-1:0] acc_index;
        logic [IN_BYTES_W-1:0]  input_bytes;
        logic [RATIO_W-1:0]     ratio;
        logic                   single;
        logic [MEM_INDEX_W-1:0] mem;
    } cmd_t;

    typedef struct packed {
        logic [FP_W-1:0]        fp;
        logic                   single;
        logic [MEM_INDEX_W-1:0] mem;
        coh_mode_t              mode;
    } entry_rec_t;

    localparam int ENTRY_REC_W = $bits(entry_rec_t);

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOKUP,
        BK_RETIRE,
        BK_DIV,
        BK_FP,
        BK_ADD,
        BK_MODE,
        BK_OUT
    } bk_state_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_sub(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        return (b > a) ? {SUM_W{1'b0}} : a - b;
    endfunction

endpackage

// ----- rtl/core/acms_ram.sv -----
// ----------------------------------------------------------------------------
// acms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module acms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/acms_div.sv -----
// ----------------------------------------------------------------------------
// acms_div
// Radix-2 restoring divider: input size over load/store ratio, one bit a cycle.
// ----------------------------------------------------------------------------
module acms_div
    import acms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [IN_BYTES_W-1:0] dividend,
    input  logic [RATIO_W-1:0]    divisor,
    output logic                  busy,
    output logic [IN_BYTES_W-1:0] quotient
);

    logic                  busy_reg;
    logic                  busy_next;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIV_CNT_W-1:0]  cnt_next;
    logic [IN_BYTES_W-1:0] quo_reg;
    logic [RATIO_W-1:0]    rem_reg;
    logic [RATIO_W-1:0]    dvs_reg;
    logic [RATIO_W:0]      shifted;
    logic [RATIO_W:0]      diff;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[IN_BYTES_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[IN_BYTES_W-2:0], ge};
            rem_reg <= ge ? diff[RATIO_W-1:0] : shifted[RATIO_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/acms_front.sv -----
// ----------------------------------------------------------------------------
// acms_front
// Takes event beats and classifies them into queue commands.
// ----------------------------------------------------------------------------
module acms_front
    import acms_pkg::*;
#(
    parameter int NUM_ACCELERATORS = 16,
    parameter int NUM_MEMORIES     = 4
) (
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   func,
    input  logic [ACC_INDEX_W-1:0] acc_index,
    input  logic [IN_BYTES_W-1:0]  input_bytes,
    input  logic [RATIO_W-1:0]     load_store_ratio,
    input  logic [POLICY_W-1:0]    policy,
    input  logic [MEM_INDEX_W-1:0] mem_index,
    input  logic                   q_full,
    output logic                   push,
    output cmd_t                   push_item
);

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.is_done     = (func == FUNC_DONE);
        push_item.in_range    = (32'(acc_index) < NUM_ACCELERATORS);
        push_item.acc_index   = acc_index;
        push_item.input_bytes = input_bytes;
        // zero ratio counts as one
        push_item.ratio       = (load_store_ratio == '0) ?
                                {{(RATIO_W-1){1'b0}}, 1'b1} : load_store_ratio;
        push_item.single      = (policy == POL_PREFERRED) || (policy == POL_LEAST_LOADED);
        // index is below twice the memory count, one subtract wraps it
        push_item.mem         = (32'(mem_index) >= NUM_MEMORIES) ?
                                MEM_INDEX_W'(32'(mem_index) - NUM_MEMORIES) : mem_index;
    end

endmodule

// ----- rtl/core/acms_queue.sv -----
// ----------------------------------------------------------------------------
// acms_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module acms_queue
    import acms_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_item,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cmd_t q_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/core/acms_back.sv -----
// ----------------------------------------------------------------------------
// acms_back
// Executes queued commands: entry lookup, retire, footprint, sums, mode.
// ----------------------------------------------------------------------------
`include "accel_coherence_mode_selector_unit_macros.svh"

module acms_back
    import acms_pkg::*;
#(
    parameter int NUM_ACCELERATORS = 16,
    parameter int NUM_MEMORIES     = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   q_valid,
    input  cmd_t                   q_item,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [MODE_W-1:0]      coherence,
    output logic [FP_W-1:0]        entry_footprint,
    output logic [SUM_W-1:0]       total_footprint,
    output logic [COUNT_W-1:0]     active_count
);

    localparam int AW = (NUM_ACCELERATORS > 1) ? $clog2(NUM_ACCELERATORS) : 1;
    localparam int MW = $clog2(NUM_MEMORIES);

    bk_state_t        state_reg;
    bk_state_t        state_next;

    cmd_t             cur_reg;
    logic [FP_W-1:0]  st_fp_reg;
    logic             st_single_reg;
    logic [MEM_INDEX_W-1:0] st_mem_reg;
    coh_mode_t        st_mode_reg;
    logic             st_active_reg;
    logic [FP_W-1:0]  fp_reg;
    coh_mode_t        mode_reg;

    logic [NUM_ACCELERATORS-1:0] active_reg;
    logic [NUM_ACCELERATORS-1:0] written_reg;
    logic [SUM_W-1:0]   mem_load_reg [NUM_MEMORIES];
    logic [SUM_W-1:0]   total_reg;
    logic [COUNT_W-1:0] count_reg;

    logic               out_valid_reg;
    coh_mode_t          out_mode_reg;
    logic [FP_W-1:0]    out_fp_reg;
    logic [SUM_W-1:0]   out_total_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               div_start;
    logic               div_busy;
    logic [IN_BYTES_W-1:0] div_q;
    logic               do_retire;
    logic               do_fp;
    logic               do_add;
    logic               ram_we;
    logic               out_load;

    logic [ENTRY_WIDE_W-1:0] q_entry_wide;
    logic [ENTRY_WIDE_W-1:0] cur_entry_wide;
    logic [AW-1:0]           raddr;
    logic [AW-1:0]           cur_addr;
    logic [MEM_WIDE_W-1:0]   cur_mem_wide;
    logic [MEM_WIDE_W-1:0]   st_mem_wide;
    logic [MW-1:0]           cur_msel;
    logic [MW-1:0]           st_msel;

    logic [ENTRY_REC_W-1:0]  ram_rdata;
    entry_rec_t              rd_rec;
    entry_rec_t              wr_rec;

    logic [SUM_W-1:0]   st_fp32;
    logic [SUM_W-1:0]   fp32;
    logic [SUM_W-1:0]   sel_load;
    logic [SUM_W-1:0]   thresh;
    coh_mode_t          mode_calc;
    logic [IN_BYTES_W:0] fp_sum;

    assign q_entry_wide   = {{(ENTRY_WIDE_W-ACC_INDEX_W){1'b0}}, q_item.acc_index};
    assign cur_entry_wide = {{(ENTRY_WIDE_W-ACC_INDEX_W){1'b0}}, cur_reg.acc_index};
    assign raddr          = q_entry_wide[AW-1:0];
    assign cur_addr       = cur_entry_wide[AW-1:0];
    assign cur_mem_wide   = {{(MEM_WIDE_W-MEM_INDEX_W){1'b0}}, cur_reg.mem};
    assign st_mem_wide    = {{(MEM_WIDE_W-MEM_INDEX_W){1'b0}}, st_mem_reg};
    assign cur_msel       = cur_mem_wide[MW-1:0];
    assign st_msel        = st_mem_wide[MW-1:0];

    assign st_fp32 = {{(SUM_W-FP_W){1'b0}}, st_fp_reg};
    assign fp32    = {{(SUM_W-FP_W){1'b0}}, fp_reg};
    assign rd_rec  = entry_rec_t'(ram_rdata);
    assign fp_sum  = (IN_BYTES_W+1)'(cur_reg.input_bytes >> cfg.access_shift)
                   + (IN_BYTES_W+1)'(div_q);

    acms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (q_item.input_bytes),
        .divisor  (q_item.ratio),
        .busy     (div_busy),
        .quotient (div_q)
    );

    acms_ram #(
        .WIDTH (ENTRY_REC_W),
        .DEPTH (NUM_ACCELERATORS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_addr),
        .wdata (wr_rec),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:   if (q_valid) state_next = BK_LOOKUP;
            BK_LOOKUP: state_next = cur_reg.in_range ? BK_RETIRE : BK_OUT;
            BK_RETIRE: state_next = cur_reg.is_done ? BK_OUT : BK_DIV;
            BK_DIV:    if (!div_busy) state_next = BK_FP;
            BK_FP:     state_next = BK_ADD;
            BK_ADD:    state_next = BK_MODE;
            BK_MODE:   state_next = BK_OUT;
            BK_OUT:    if (!out_valid_reg || !out_stall) state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        pop       = (state_reg == BK_IDLE) && q_valid;
        div_start = pop && !q_item.is_done && q_item.in_range;
        do_retire = (state_reg == BK_RETIRE) && st_active_reg;
        do_fp     = (state_reg == BK_FP);
        do_add    = (state_reg == BK_ADD);
        ram_we    = (state_reg == BK_MODE);
        out_load  = (state_reg == BK_OUT) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        sel_load = cur_reg.single ? mem_load_reg[cur_msel] : total_reg;
        thresh   = cur_reg.single ? {1'b0, cfg.llc_bytes[SUM_W-1:1]} : cfg.llc_bytes;
        priority if (fp32 < cfg.private_cache_bytes)
        begin
            mode_calc = COH_FULL;
        end
        else if (sel_load > thresh)
        begin
            mode_calc = COH_NONCOH;
        end
        else
        begin
            mode_calc = COH_LLC;
        end
        wr_rec.fp     = fp_reg;
        wr_rec.single = cur_reg.single;
        wr_rec.mem    = cur_reg.mem;
        wr_rec.mode   = mode_calc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            active_reg    <= '0;
            written_reg   <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MEMORIES; i++)
            begin
                mem_load_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (do_retire)
            begin
                active_reg[cur_addr] <= 1'b0;
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - 1'b1;
                end
                total_reg <= sat_sub(total_reg, st_fp32);
                if (st_single_reg)
                begin
                    mem_load_reg[st_msel] <= sat_sub(mem_load_reg[st_msel], st_fp32);
                end
                else
                begin
                    mem_load_reg[0] <= sat_sub(mem_load_reg[0], st_fp32 >> 1);
                    mem_load_reg[1] <= sat_sub(mem_load_reg[1], st_fp32 >> 1);
                end
            end
            if (do_add)
            begin
                active_reg[cur_addr] <= 1'b1;
                if (count_reg != COUNT_MAX)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                total_reg <= sat_add(total_reg, fp32);
                if (cur_reg.single)
                begin
                    mem_load_reg[cur_msel] <= sat_add(mem_load_reg[cur_msel], fp32);
                end
                else
                begin
                    mem_load_reg[0] <= sat_add(mem_load_reg[0], fp32 >> 1);
                    mem_load_reg[1] <= sat_add(mem_load_reg[1], fp32 >> 1);
                end
            end
            if (ram_we)
            begin
                written_reg[cur_addr] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == BK_LOOKUP)
        begin
            // unwritten entries read as zero
            if (cur_reg.in_range && written_reg[cur_addr])
            begin
                st_fp_reg     <= rd_rec.fp;
                st_single_reg <= rd_rec.single;
                st_mem_reg    <= rd_rec.mem;
                st_mode_reg   <= rd_rec.mode;
            end
            else
            begin
                st_fp_reg     <= '0;
                st_single_reg <= 1'b0;
                st_mem_reg    <= '0;
                st_mode_reg   <= COH_FULL;
            end
            st_active_reg <= cur_reg.in_range && active_reg[cur_addr];
        end
        if (do_fp)
        begin
            fp_reg <= {fp_sum, 2'b00};
        end
        if (ram_we)
        begin
            mode_reg <= mode_calc;
        end
        if (out_load)
        begin
            out_total_reg <= total_reg;
            out_count_reg <= count_reg;
            if (!cur_reg.in_range)
            begin
                out_mode_reg <= COH_FULL;
                out_fp_reg   <= '0;
            end
            else if (cur_reg.is_done)
            begin
                out_mode_reg <= st_mode_reg;
                out_fp_reg   <= st_fp_reg;
            end
            else
            begin
                out_mode_reg <= mode_reg;
                out_fp_reg   <= fp_reg;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign coherence       = out_mode_reg;
    assign entry_footprint = out_fp_reg;
    assign total_footprint = out_total_reg;
    assign active_count    = out_count_reg;

    `ACMS_ASSERT_IMP(a_div_idle_between_cmds, state_reg == BK_IDLE, !div_busy)
    `ACMS_ASSERT_IMP(a_ram_write_invoke_only, ram_we, cur_reg.in_range && !cur_reg.is_done)
    `ACMS_ASSERT_NXT(a_mode_marks_entry, state_reg == BK_MODE, written_reg[cur_addr] && active_reg[cur_addr])
    `ACMS_ASSERT_IMP(a_count_tracks_active, (NUM_ACCELERATORS < 32) && (state_reg == BK_IDLE), 32'(count_reg) == $countones(active_reg))

endmodule

// ----- rtl/core/accel_coherence_mode_selector_unit.sv -----
// ----------------------------------------------------------------------------
// accel_coherence_mode_selector_unit
// Tracks accelerator footprints and memory loads, picks a coherence mode.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+-----------------------------------
//   in      | input     | in_valid/stall   | func acc_index input_bytes
//           |           |                  | load_store_ratio policy mem_index
//   out     | output    | out_valid/stall  | coherence entry_footprint
//           |           |                  | total_footprint active_count
//   apb     | input     | psel/penable     | paddr pwdata prdata (pready = 1)
//
// Invoke beat: lookup, retire, radix-2 divide (input_bytes / load_store_ratio),
// footprint, add, mode, output. Done beat: lookup, retire, output.
// Out-of-range beat: lookup, output. Beats reach the back end via the queue.
// Reset clears sums, count and the entry flag vectors at once; no clearing pass.
// A two-deep command queue lets in accept while a command runs; the output
// register holds a result under out_stall while the next command proceeds.
// ----------------------------------------------------------------------------
module accel_coherence_mode_selector_unit
    import acms_pkg::*;
#(
    parameter int NUM_ACCELERATORS = 16,
    parameter int NUM_MEMORIES     = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   func,
    input  logic [ACC_INDEX_W-1:0] acc_index,
    input  logic [IN_BYTES_W-1:0]  input_bytes,
    input  logic [RATIO_W-1:0]     load_store_ratio,
    input  logic [POLICY_W-1:0]    policy,
    input  logic [MEM_INDEX_W-1:0] mem_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [MODE_W-1:0]      coherence,
    output logic [FP_W-1:0]        entry_footprint,
    output logic [SUM_W-1:0]       total_footprint,
    output logic [COUNT_W-1:0]     active_count,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready
);

    cfg_t                 cfg_reg;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] reg_idx;

    logic                 q_full;
    logic                 q_push;
    cmd_t                 q_push_item;
    logic                 q_pop;
    logic                 q_valid;
    cmd_t                 q_item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.access_shift        <= '0;
            cfg_reg.private_cache_bytes <= PRIVATE_RESET;
            cfg_reg.llc_bytes           <= LLC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                REG_ACCESS_SHIFT:  cfg_reg.access_shift        <= pwdata[SHIFT_W-1:0];
                REG_PRIVATE_CACHE: cfg_reg.private_cache_bytes <= pwdata;
                REG_LLC:           cfg_reg.llc_bytes           <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ACCESS_SHIFT:  prdata = {{(PDATA_W-SHIFT_W){1'b0}}, cfg_reg.access_shift};
            REG_PRIVATE_CACHE: prdata = cfg_reg.private_cache_bytes;
            REG_LLC:           prdata = cfg_reg.llc_bytes;
            default:           prdata = '0;
        endcase
    end

    acms_front #(
        .NUM_ACCELERATORS (NUM_ACCELERATORS),
        .NUM_MEMORIES     (NUM_MEMORIES)
    ) u_front (
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .acc_index        (acc_index),
        .input_bytes      (input_bytes),
        .load_store_ratio (load_store_ratio),
        .policy           (policy),
        .mem_index        (mem_index),
        .q_full           (q_full),
        .push             (q_push),
        .push_item        (q_push_item)
    );

    acms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    acms_back #(
        .NUM_ACCELERATORS (NUM_ACCELERATORS),
        .NUM_MEMORIES     (NUM_MEMORIES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .coherence       (coherence),
        .entry_footprint (entry_footprint),
        .total_footprint (total_footprint),
        .active_count    (active_count)
    );

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for accel_coherence_mode_selector_unit
// Sends invoke and done events with random gaps and output stalls. An internal
// predictor tracks footprints, memory loads and modes, and every result beat
// is checked field by field. Registers are written over APB between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import acms_pkg::*;

    localparam logic FUNC_INVOKE = ~FUNC_DONE;
    localparam logic [POLICY_W-1:0] POL_INTERLEAVED = 2'd2;
    localparam logic [POLICY_W-1:0] POL_UNDEFINED   = 2'd3;
    localparam int NUM_ENTRIES = 16;
    localparam int NUM_MEMS    = 4;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        coh_mode_t              mode;
        logic [FP_W-1:0]        fp;
        logic [SUM_W-1:0]       total;
        logic [COUNT_W-1:0]     count;
    } selector_result_t;

    class coherence_scoreboard;
        logic [SHIFT_W-1:0]     shift_cfg;
        logic [SUM_W-1:0]       private_cfg;
        logic [SUM_W-1:0]       llc_cfg;
        logic [FP_W-1:0]        fp_tab[NUM_ENTRIES];
        bit                     single_tab[NUM_ENTRIES];
        logic [MEM_INDEX_W-1:0] mem_tab[NUM_ENTRIES];
        coh_mode_t              mode_tab[NUM_ENTRIES];
        bit                     active_tab[NUM_ENTRIES];
        logic [SUM_W-1:0]       mem_load[NUM_MEMS];
        logic [SUM_W-1:0]       total_load;
        logic [COUNT_W-1:0]     live_count;
        selector_result_t       pending_q[$];
        int                     mismatches;

        function new();
            shift_cfg   = '0;
            private_cfg = PRIVATE_RESET;
            llc_cfg     = LLC_RESET;
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                fp_tab[i]     = '0;
                single_tab[i] = 0;
                mem_tab[i]    = '0;
                mode_tab[i]   = COH_FULL;
                active_tab[i] = 0;
            end
            for (int i = 0; i < NUM_MEMS; i++)
                mem_load[i] = '0;
            total_load = '0;
            live_count = '0;
            mismatches = 0;
        endfunction

        function void set_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
            case (idx)
                REG_ACCESS_SHIFT:  shift_cfg = val[SHIFT_W-1:0];
                REG_PRIVATE_CACHE: private_cfg = val;
                REG_LLC:           llc_cfg = val;
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(input logic [REG_IDX_W-1:0] idx);
            case (idx)
                REG_ACCESS_SHIFT:  return {27'd0, shift_cfg};
                REG_PRIVATE_CACHE: return private_cfg;
                REG_LLC:           return llc_cfg;
                default:           return '0;
            endcase
        endfunction

        function logic [SUM_W-1:0] load_up(input logic [SUM_W-1:0] a, input logic [SUM_W-1:0] b);
            logic [SUM_W-1:0] s;
            s = a + b;
            return (s < a) ? '1 : s;
        endfunction

        function logic [SUM_W-1:0] load_down(input logic [SUM_W-1:0] a,
                                             input logic [SUM_W-1:0] b);
            return (a < b) ? '0 : a - b;
        endfunction

        function void release_entry(input int e);
            logic [SUM_W-1:0] fp;
            fp = {5'd0, fp_tab[e]};
            active_tab[e] = 0;
            if (live_count != 0)
                live_count--;
            total_load = load_down(total_load, fp);
            if (single_tab[e])
                mem_load[mem_tab[e]] = load_down(mem_load[mem_tab[e]], fp);
            else
            begin
                mem_load[0] = load_down(mem_load[0], fp >> 1);
                mem_load[1] = load_down(mem_load[1], fp >> 1);
            end
        endfunction

        function void note_event(input logic f, input logic [ACC_INDEX_W-1:0] idx,
                                 input logic [IN_BYTES_W-1:0] inb,
                                 input logic [RATIO_W-1:0] ratio,
                                 input logic [POLICY_W-1:0] pol,
                                 input logic [MEM_INDEX_W-1:0] mem);
            selector_result_t r;
            logic [SUM_W-1:0] outsz, fp, load, thresh;
            logic [RATIO_W-1:0] div;
            bit single;
            if (f == FUNC_DONE)
            begin
                if (active_tab[idx])
                    release_entry(idx);
                r.mode = mode_tab[idx];
                r.fp   = fp_tab[idx];
            end
            else
            begin
                single = (pol == POL_PREFERRED) || (pol == POL_LEAST_LOADED);
                if (active_tab[idx])
                    release_entry(idx);
                div   = (ratio == 0) ? 8'd1 : ratio;
                outsz = {8'd0, inb} / {24'd0, div};
                fp    = (({8'd0, inb} >> shift_cfg) + outsz) << 2;
                active_tab[idx] = 1;
                if (live_count != COUNT_MAX)
                    live_count++;
                fp_tab[idx]     = fp[FP_W-1:0];
                single_tab[idx] = single;
                mem_tab[idx]    = mem;
                total_load      = load_up(total_load, fp);
                if (single)
                begin
                    mem_load[mem] = load_up(mem_load[mem], fp);
                    load   = mem_load[mem];
                    thresh = llc_cfg >> 1;
                end
                else
                begin
                    mem_load[0] = load_up(mem_load[0], fp >> 1);
                    mem_load[1] = load_up(mem_load[1], fp >> 1);
                    load   = total_load;
                    thresh = llc_cfg;
                end
                if (fp < private_cfg)
                    r.mode = COH_FULL;
                else if (load > thresh)
                    r.mode = COH_NONCOH;
                else
                    r.mode = COH_LLC;
                mode_tab[idx] = r.mode;
                r.fp = fp[FP_W-1:0];
            end
            r.total = total_load;
            r.count = live_count;
            pending_q.push_back(r);
        endfunction

        function void compare_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH %s: expected %0h, got %0h", name, want, got);
            end
        endfunction

        function void check_result(input selector_result_t act);
            selector_result_t want;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH unexpected result beat: %p", act);
                return;
            end
            want = pending_q.pop_front();
            compare_field("coherence", 32'(want.mode), 32'(act.mode));
            compare_field("entry_footprint", 32'(want.fp), 32'(act.fp));
            compare_field("total_footprint", want.total, act.total);
            compare_field("active_count", 32'(want.count), 32'(act.count));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   func;
    logic [ACC_INDEX_W-1:0] acc_index;
    logic [IN_BYTES_W-1:0]  input_bytes;
    logic [RATIO_W-1:0]     load_store_ratio;
    logic [POLICY_W-1:0]    policy;
    logic [MEM_INDEX_W-1:0] mem_index;
    logic                   out_valid;
    logic                   out_stall;
    logic [MODE_W-1:0]      coherence;
    logic [FP_W-1:0]        entry_footprint;
    logic [SUM_W-1:0]       total_footprint;
    logic [COUNT_W-1:0]     active_count;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    coherence_scoreboard sb = new();
    int  cycles;
    int  stall_left;
    bit  burst;

    accel_coherence_mode_selector_unit uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .acc_index        (acc_index),
        .input_bytes      (input_bytes),
        .load_store_ratio (load_store_ratio),
        .policy           (policy),
        .mem_index        (mem_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .coherence        (coherence),
        .entry_footprint  (entry_footprint),
        .total_footprint  (total_footprint),
        .active_count     (active_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("accel_coherence_mode_selector_unit verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{coh_mode_t'(coherence), entry_footprint, total_footprint,
                              active_count});
    end

    // output stall: short and long stalls, free runs of varied length
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            if (!out_stall)
            begin
                out_stall = 1;
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
            end
            else
            begin
                out_stall = 0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 20);
            end
        end
        else
            stall_left--;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_event(input logic f, input logic [ACC_INDEX_W-1:0] idx,
                              input logic [IN_BYTES_W-1:0] inb,
                              input logic [RATIO_W-1:0] ratio,
                              input logic [POLICY_W-1:0] pol,
                              input logic [MEM_INDEX_W-1:0] mem);
        bit taken;
        func             = f;
        acc_index        = idx;
        input_bytes      = inb;
        load_store_ratio = ratio;
        policy           = pol;
        mem_index        = mem;
        in_valid         = 1;
        do
        begin
            @(posedge clk);
            taken = !in_stall;
        end
        while (!taken);
        sb.note_event(f, idx, inb, ratio, pol, mem);
        @(negedge clk);
    endtask

    task automatic sender_gap();
        int g;
        int pick;
        pick = $urandom_range(0, 99);
        if (burst || pick < 50)
            g = 0;
        else if (pick < 85)
            g = $urandom_range(1, 3);
        else if (pick < 95)
            g = $urandom_range(4, 10);
        else
            g = $urandom_range(20, 60);
        if (g > 0)
        begin
            in_valid = 0;
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid = 0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] got;
        psel    = 1;
        penable = 0;
        pwrite  = 1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel    = 0;
        penable = 0;
        pwrite  = 0;
        sb.set_reg(idx, val);
        @(negedge clk);
        psel = 1;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    = 0;
        penable = 0;
        sb.compare_field("register readback", sb.reg_value(idx), got);
    endtask

    task automatic run_phase(input logic [SHIFT_W-1:0] sh, input logic [31:0] pc,
                             input logic [31:0] llc, input bit no_gaps, input int beats);
        logic [IN_BYTES_W-1:0] inb;
        write_reg(REG_ACCESS_SHIFT, {27'd0, sh});
        write_reg(REG_PRIVATE_CACHE, pc);
        write_reg(REG_LLC, llc);
        burst = no_gaps;
        for (int n = 0; n < beats; n++)
        begin
            case ($urandom_range(0, 3))
                0:       inb = IN_BYTES_W'($urandom_range(0, 255));
                1:       inb = IN_BYTES_W'($urandom_range(0, 65535));
                default: inb = IN_BYTES_W'($urandom);
            endcase
            sender_gap();
            send_event(($urandom_range(0, 99) < 35) ? FUNC_DONE : FUNC_INVOKE,
                       ACC_INDEX_W'($urandom_range(0, NUM_ENTRIES - 1)), inb,
                       RATIO_W'($urandom), POLICY_W'($urandom), MEM_INDEX_W'($urandom));
        end
        drain();
    endtask

    initial
    begin
        cycles           = 0;
        stall_left       = 0;
        burst            = 0;
        rst_n            = 0;
        in_valid         = 0;
        func             = FUNC_INVOKE;
        acc_index        = '0;
        input_bytes      = '0;
        load_store_ratio = '0;
        policy           = POL_PREFERRED;
        mem_index        = '0;
        out_stall        = 0;
        psel             = 0;
        penable          = 0;
        pwrite           = 0;
        paddr            = '0;
        pwdata           = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // zero size and zero ratio, full size at both ratio ends, all policies
        send_event(FUNC_INVOKE, 4'd0, 24'h000000, 8'd0, POL_PREFERRED, 2'd0);
        send_event(FUNC_INVOKE, 4'd1, 24'hFFFFFF, 8'd1, POL_LEAST_LOADED, 2'd3);
        send_event(FUNC_INVOKE, 4'd2, 24'hFFFFFF, 8'd255, POL_INTERLEAVED, 2'd1);
        send_event(FUNC_INVOKE, 4'd3, 24'h012345, 8'd0, POL_UNDEFINED, 2'd2);
        send_event(FUNC_INVOKE, 4'd1, 24'h0003E8, 8'd7, POL_PREFERRED, 2'd1);
        send_event(FUNC_DONE, 4'd5, 24'h000000, 8'd0, POL_PREFERRED, 2'd0);
        send_event(FUNC_DONE, 4'd1, 24'hFFFFFF, 8'd255, POL_UNDEFINED, 2'd3);
        send_event(FUNC_DONE, 4'd1, 24'h000000, 8'd0, POL_PREFERRED, 2'd0);
        send_event(FUNC_INVOKE, 4'd15, 24'hFFFFFF, 8'd2, POL_INTERLEAVED, 2'd3);
        send_event(FUNC_INVOKE, 4'd14, 24'h800000, 8'd128, POL_LEAST_LOADED, 2'd2);
        send_event(FUNC_INVOKE, 4'd7, 24'hAAAAAA, 8'hAA, POL_PREFERRED, 2'd2);
        send_event(FUNC_INVOKE, 4'd8, 24'h555555, 8'h55, POL_LEAST_LOADED, 2'd1);
        send_event(FUNC_INVOKE, 4'd9, 24'h00FFFF, 8'd3, POL_PREFERRED, 2'd3);
        send_event(FUNC_INVOKE, 4'd7, 24'h3FFFFF, 8'd1, POL_UNDEFINED, 2'd0);
        send_event(FUNC_DONE, 4'd0, 24'h000000, 8'd0, POL_PREFERRED, 2'd0);
        send_event(FUNC_DONE, 4'd2, 24'h000000, 8'd0, POL_PREFERRED, 2'd0);
        send_event(FUNC_DONE, 4'd3, 24'h000000, 8'd0, POL_PREFERRED, 2'd0);
        send_event(FUNC_DONE, 4'd14, 24'h000000, 8'd0, POL_PREFERRED, 2'd0);
        send_event(FUNC_DONE, 4'd15, 24'h000000, 8'd0, POL_PREFERRED, 2'd0);
        send_event(FUNC_DONE, 4'd7, 24'h000000, 8'd0, POL_PREFERRED, 2'd0);
        drain();

        run_phase(5'd0, 32'd65536, 32'd1048576, 0, 280);
        run_phase(5'd31, 32'd0, 32'd0, 0, 280);
        run_phase(5'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 280);
        run_phase(5'd2, 32'h0000_4000, 32'h0080_0000, 0, 280);
        run_phase(SHIFT_W'($urandom_range(0, 8)), $urandom_range(0, 1 << 22),
                  $urandom_range(0, 1 << 27), 0, 290);
        run_phase(SHIFT_W'($urandom_range(0, 31)), $urandom_range(0, 1 << 26),
                  $urandom_range(0, 1 << 29), 0, 290);

        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("accel_coherence_mode_selector_unit verification clean");
        else
            $display("accel_coherence_mode_selector_unit verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/acms_pkg.sv
rtl/core/acms_ram.sv
rtl/core/acms_div.sv
rtl/core/acms_front.sv
rtl/core/acms_queue.sv
rtl/core/acms_back.sv
rtl/core/accel_coherence_mode_selector_unit.sv
verif/tb_top.sv
